FILE: hdl/display_test_pattern_generator_unit_defines.svh
// Assertion macros used by the checker file of the test pattern generator.
// No dependencies; include by bare file name.
`ifndef DISPLAY_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define DISPLAY_TEST_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// Check a property while reset is released.
`define DTPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define DTPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dtpg_pkg.sv
// Shared types and constants of the display test pattern generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dtpg_pkg;

  // Active area and field widths
  localparam int unsigned H_RES    = 1920;
  localparam int unsigned V_RES    = 1080;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned MODE_W   = 3;
  // Width that holds any resolution value up to 4096
  localparam int unsigned DIM_W    = 13;

  // RGB332 colors
  localparam logic [COLOR_W-1:0] COL_BLACK   = 8'h00;
  localparam logic [COLOR_W-1:0] COL_WHITE   = 8'hFF;
  localparam logic [COLOR_W-1:0] COL_CYAN    = 8'h1F;
  localparam logic [COLOR_W-1:0] COL_MAGENTA = 8'hE3;
  localparam logic [COLOR_W-1:0] COL_YELLOW  = 8'hFC;

  // Crosshair and ramp geometry
  localparam int unsigned TICK_STEP  = 16;
  localparam int unsigned TICK_LO    = 4;
  localparam int unsigned TICK_HI    = 12;
  localparam int unsigned PATCH_NEAR = 32;
  localparam int unsigned PATCH_FAR  = 96;
  localparam int unsigned PATCH_SIZE = 64;
  localparam int unsigned RAMP_ROWS  = 64;
  localparam int unsigned RAMP_SPAN  = 256;

  localparam logic [DIM_W-1:0] H_RES_D   = DIM_W'(H_RES);
  localparam logic [DIM_W-1:0] V_RES_D   = DIM_W'(V_RES);
  localparam logic [DIM_W-1:0] H_LAST    = DIM_W'(H_RES - 1);
  localparam logic [DIM_W-1:0] V_LAST    = DIM_W'(V_RES - 1);
  localparam logic [DIM_W-1:0] H_MID     = DIM_W'(H_RES / 2);
  localparam logic [DIM_W-1:0] V_MID     = DIM_W'(V_RES / 2);
  localparam logic [DIM_W-1:0] FAR_X     = DIM_W'(H_RES - PATCH_FAR);
  localparam logic [DIM_W-1:0] FAR_Y     = DIM_W'(V_RES - PATCH_FAR);
  localparam logic [DIM_W-1:0] NEAR_D    = DIM_W'(PATCH_NEAR);
  localparam logic [DIM_W-1:0] PSIZE_D   = DIM_W'(PATCH_SIZE);
  localparam logic [DIM_W-1:0] TSTEP_D   = DIM_W'(TICK_STEP);
  localparam logic [DIM_W-1:0] TLO_D     = DIM_W'(TICK_LO);
  localparam logic [DIM_W-1:0] THI_D     = DIM_W'(TICK_HI);
  localparam logic [DIM_W-1:0] RAMP_TOP  = DIM_W'(V_RES - RAMP_ROWS);
  localparam int unsigned      TSTEP_LOG = $clog2(TICK_STEP);

  // Ramp x*RAMP_SPAN/H_RES by exact reciprocal: numerator has RAMP_NUM_W bits
  localparam int unsigned      SPAN_LOG   = $clog2(RAMP_SPAN);
  localparam int unsigned      RAMP_NUM_W = COORD_W + SPAN_LOG;
  localparam int unsigned      RAMP_SHIFT = RAMP_NUM_W + $clog2(H_RES);
  localparam int unsigned      RAMP_MUL_W = RAMP_NUM_W + 1;
  localparam longint unsigned  RAMP_MUL_L =
    ((64'd1 << RAMP_SHIFT) + 64'(H_RES) - 64'd1) / 64'(H_RES);
  localparam logic [RAMP_MUL_W-1:0] RAMP_MUL = RAMP_MUL_W'(RAMP_MUL_L);
  localparam int unsigned      RAMP_PROD_W = COORD_W + RAMP_MUL_W;
  localparam int unsigned      RAMP_Q_LSB  = RAMP_SHIFT - SPAN_LOG;

  typedef enum logic [MODE_W-1:0] {
    PAT_CHECKER = 3'd0,
    PAT_VSTRIPE = 3'd1,
    PAT_HSTRIPE = 3'd2,
    PAT_CROSS   = 3'd3,
    PAT_RAMP    = 3'd4
  } pattern_mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_coord_t;

endpackage

FILE: hdl/display_test_pattern_generator_unit.sv
// Display test pattern generator: coordinate in, RGB332 color out.
// Depends on dtpg_pkg, dtpg_in_stage, dtpg_color and dtpg_out_stage.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one pixel coordinate per
//   transfer: in_pixel_x and in_pixel_y.
//   Result channel (out_valid/out_ready) gives one out_pixel_color per input
//   transfer, in order.
//   Configuration channel (cfg_valid/cfg_ready) writes the 3-bit pattern
//   mode: 0 checker, 1 vertical stripes, 2 horizontal stripes, 3 crosshair,
//   4 ramp; other codes show the checkerboard. cfg_ready is always high.
//   Write the mode only while no pixel is in flight.
// Timing:
//   An input transfer reaches out_valid through one input register, the
//   pattern logic with its single ramp multiplier, then the result register.
//   Throughput is one pixel per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds its color and the
//   input register holds one more coordinate; in_ready drops only when both
//   are full. Reset clears both valid flags and sets the mode to checker.
`timescale 1ns / 1ps

module display_test_pattern_generator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtpg_pkg::COORD_W-1:0]  in_pixel_x,
  input  logic [dtpg_pkg::COORD_W-1:0]  in_pixel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtpg_pkg::COLOR_W-1:0]  out_pixel_color,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtpg_pkg::MODE_W-1:0]   cfg_pattern_mode
);
  import dtpg_pkg::*;

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  pixel_coord_t       in_coord, s1_coord;
  logic               s1_valid, take;
  logic [COLOR_W-1:0] color;

  // Mode register, written on a configuration transfer
  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_pattern_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_W'(PAT_CHECKER);
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign in_coord.x = in_pixel_x;
  assign in_coord.y = in_pixel_y;

  dtpg_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_coord (in_coord),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_coord (s1_coord)
  );

  dtpg_color u_color (
    .mode  (pattern_mode_t'(mode_r)),
    .coord (s1_coord),
    .color (color)
  );

  dtpg_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .color_in  (color),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_color (out_pixel_color)
  );

endmodule

FILE: hdl/dtpg_in_stage.sv
// Input register of the test pattern generator: holds one coordinate transfer.
// Depends on dtpg_pkg.
`timescale 1ns / 1ps

module dtpg_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dtpg_pkg::pixel_coord_t in_coord,
  input  logic                  take,
  output logic                  s1_valid,
  output dtpg_pkg::pixel_coord_t s1_coord
);
  import dtpg_pkg::*;

  logic         valid_r, valid_nxt;
  pixel_coord_t coord_r;
  logic         load;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      coord_r <= in_coord;
    end
  end

  assign s1_valid = valid_r;
  assign s1_coord = coord_r;

endmodule

FILE: hdl/dtpg_color.sv
// Pattern logic: maps a registered coordinate and the mode to an RGB332 color.
// Depends on dtpg_pkg.
`timescale 1ns / 1ps

module dtpg_color (
  input  dtpg_pkg::pattern_mode_t      mode,
  input  dtpg_pkg::pixel_coord_t       coord,
  output logic [dtpg_pkg::COLOR_W-1:0] color
);
  import dtpg_pkg::*;

  logic [DIM_W-1:0]       x, y;
  logic                   outside;
  logic [COLOR_W-1:0]     white_or_black_chk;
  logic [COLOR_W-1:0]     cross_color;
  logic [COLOR_W-1:0]     ramp_color;
  logic [RAMP_PROD_W-1:0] ramp_prod;
  logic                   in_x_near, in_x_far, in_y_near, in_y_far;
  logic                   p0, p1, p2, p3;
  logic                   patch_par;
  logic                   tick_row, tick_col;

  assign x = DIM_W'(coord.x);
  assign y = DIM_W'(coord.y);
  assign outside = (x >= H_RES_D) || (y >= V_RES_D);

  assign white_or_black_chk = (coord.x[0] ^ coord.y[0]) ? COL_WHITE : COL_BLACK;

  // Patch windows along each axis
  assign in_x_near = (x >= NEAR_D) && (x < NEAR_D + PSIZE_D);
  assign in_x_far  = (x >= FAR_X)  && (x < FAR_X + PSIZE_D);
  assign in_y_near = (y >= NEAR_D) && (y < NEAR_D + PSIZE_D);
  assign in_y_far  = (y >= FAR_Y)  && (y < FAR_Y + PSIZE_D);
  assign p0 = in_x_near && in_y_near;
  assign p1 = in_x_far  && in_y_near;
  assign p2 = in_x_near && in_y_far;
  assign p3 = in_x_far  && in_y_far;

  // Parity of (x - ox) ^ (y - oy) for the first patch hit
  always_comb begin
    patch_par = coord.x[0] ^ coord.y[0];
    if (p0) begin
      patch_par = coord.x[0] ^ coord.y[0] ^ NEAR_D[0] ^ NEAR_D[0];
    end else if (p1) begin
      patch_par = coord.x[0] ^ coord.y[0] ^ FAR_X[0] ^ NEAR_D[0];
    end else if (p2) begin
      patch_par = coord.x[0] ^ coord.y[0] ^ NEAR_D[0] ^ FAR_Y[0];
    end else if (p3) begin
      patch_par = coord.x[0] ^ coord.y[0] ^ FAR_X[0] ^ FAR_Y[0];
    end
  end

  // Ruler ticks on every sixteenth row and column
  assign tick_row = (y >= TSTEP_D) && (y[TSTEP_LOG-1:0] == '0) && (x >= TLO_D) && (x < THI_D);
  assign tick_col = (x >= TSTEP_D) && (x[TSTEP_LOG-1:0] == '0) && (y >= TLO_D) && (y < THI_D);

  // Crosshair priority: the first element that matches wins
  always_comb begin
    if (p0 || p1 || p2 || p3) begin
      cross_color = patch_par ? COL_WHITE : COL_BLACK;
    end else if (tick_row || tick_col) begin
      cross_color = COL_YELLOW;
    end else if (x == H_MID) begin
      cross_color = COL_MAGENTA;
    end else if (x == '0 || x == H_LAST) begin
      cross_color = COL_WHITE;
    end else if (y == V_MID) begin
      cross_color = COL_CYAN;
    end else if (y == '0 || y == V_LAST) begin
      cross_color = COL_WHITE;
    end else begin
      cross_color = COL_BLACK;
    end
  end

  // Ramp: x*256/H_RES by reciprocal multiply, sawtooth in the bottom rows
  assign ramp_prod = RAMP_PROD_W'(coord.x) * RAMP_PROD_W'(RAMP_MUL);
  always_comb begin
    if (y >= RAMP_TOP) begin
      ramp_color = coord.x[COLOR_W-1:0];
    end else begin
      ramp_color = ramp_prod[RAMP_Q_LSB +: COLOR_W];
    end
  end

  // Select by mode; undefined codes show the checkerboard
  always_comb begin
    if (outside) begin
      color = COL_BLACK;
    end else begin
      unique case (mode)
        PAT_VSTRIPE: color = coord.x[0] ? COL_WHITE : COL_BLACK;
        PAT_HSTRIPE: color = coord.y[0] ? COL_WHITE : COL_BLACK;
        PAT_CROSS:   color = cross_color;
        PAT_RAMP:    color = ramp_color;
        default:     color = white_or_black_chk;
      endcase
    end
  end

endmodule

FILE: hdl/dtpg_out_stage.sv
// Result register of the test pattern generator: holds one color transfer.
// Depends on dtpg_pkg.
`timescale 1ns / 1ps

module dtpg_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  logic [dtpg_pkg::COLOR_W-1:0] color_in,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dtpg_pkg::COLOR_W-1:0] out_color
);
  import dtpg_pkg::*;

  logic               valid_r, valid_nxt;
  logic [COLOR_W-1:0] color_r;

  // Load when empty or when the current result leaves this cycle
  assign take = s1_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      color_r <= color_in;
    end
  end

  assign out_valid = valid_r;
  assign out_color = color_r;

endmodule

FILE: hdl/dtpg_checker.sv
// Port-level checks of the display test pattern generator, bound to the top.
// Depends on display_test_pattern_generator_unit_defines.svh and dtpg_pkg.
`timescale 1ns / 1ps
`include "display_test_pattern_generator_unit_defines.svh"

module dtpg_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dtpg_pkg::COLOR_W-1:0] out_pixel_color
);
  import dtpg_pkg::*;

  // No result survives a reset edge
  `DTPG_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "out_valid after reset")

  // A stalled result holds its color
  `DTPG_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_pixel_color), "stalled result changed")

  // After an input transfer, out_valid must be high behind the input and result registers
  `DTPG_ASSERT(a_latency, clk, rst_n, in_valid && in_ready |=> ##1 out_valid, "result missing after input transfer")

  // With the result register empty the input side is never blocked
  `DTPG_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "in_ready low with empty output")

endmodule

bind display_test_pattern_generator_unit dtpg_checker u_dtpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_color (out_pixel_color)
);

FILE: tb/display_test_pattern_generator_unit_tb.sv
// Testbench for display_test_pattern_generator_unit: drives pixel coordinates,
// predicts each RGB332 color and checks every result transfer in order.
// Depends on dtpg_pkg and the RTL of the block; needs no other files.
`timescale 1ns / 1ps

module display_test_pattern_generator_unit_tb;
  import dtpg_pkg::*;

  // Mode codes that the block treats as checkerboard
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int unsigned RANDOM_PER_PHASE = 100;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
  } pixel_expect_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [COORD_W-1:0]  in_pixel_x = '0;
  logic [COORD_W-1:0]  in_pixel_y = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COLOR_W-1:0]  out_pixel_color;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MODE_W-1:0]   cfg_pattern_mode = '0;

  pixel_expect_t       color_q[$];
  logic [MODE_W-1:0]   mode_shadow = PAT_CHECKER;
  int                  fail_count = 0;
  int                  burst_left = 0;

  display_test_pattern_generator_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_color  (out_pixel_color),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_pattern_mode (cfg_pattern_mode)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predict the color of one pixel for a given mode
  function automatic bit in_patch(int unsigned x, int unsigned y,
                                  int unsigned ox, int unsigned oy);
    return x >= ox && x < ox + PATCH_SIZE && y >= oy && y < oy + PATCH_SIZE;
  endfunction

  function automatic logic [COLOR_W-1:0] pattern_color(
      input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] px,
      input logic [COORD_W-1:0] py);
    int unsigned x;
    int unsigned y;
    int unsigned ox;
    int unsigned oy;
    int unsigned far_x;
    int unsigned far_y;
    bit          hit;
    x = px;
    y = py;
    far_x = H_RES - PATCH_FAR;
    far_y = V_RES - PATCH_FAR;
    hit = 1'b1;
    if (x >= H_RES || y >= V_RES) return COL_BLACK;
    case (mode)
      PAT_VSTRIPE: return x[0] ? COL_WHITE : COL_BLACK;
      PAT_HSTRIPE: return y[0] ? COL_WHITE : COL_BLACK;
      PAT_RAMP: begin
        if (y >= V_RES - RAMP_ROWS) return COLOR_W'(x & 8'hFF);
        return COLOR_W'(((x * RAMP_SPAN) / H_RES) & 8'hFF);
      end
      PAT_CROSS: begin
        // Patches win over everything, then ticks, then center lines and border
        if (in_patch(x, y, PATCH_NEAR, PATCH_NEAR)) begin
          ox = PATCH_NEAR; oy = PATCH_NEAR;
        end else if (in_patch(x, y, far_x, PATCH_NEAR)) begin
          ox = far_x; oy = PATCH_NEAR;
        end else if (in_patch(x, y, PATCH_NEAR, far_y)) begin
          ox = PATCH_NEAR; oy = far_y;
        end else if (in_patch(x, y, far_x, far_y)) begin
          ox = far_x; oy = far_y;
        end else begin
          ox = 0; oy = 0; hit = 1'b0;
        end
        if (hit) return (((x - ox) ^ (y - oy)) & 1) ? COL_WHITE : COL_BLACK;
        if (y >= TICK_STEP && y % TICK_STEP == 0 && x >= TICK_LO && x < TICK_HI)
          return COL_YELLOW;
        if (x >= TICK_STEP && x % TICK_STEP == 0 && y >= TICK_LO && y < TICK_HI)
          return COL_YELLOW;
        if (x == H_RES / 2) return COL_MAGENTA;
        if (x == 0 || x == H_RES - 1) return COL_WHITE;
        if (y == V_RES / 2) return COL_CYAN;
        if (y == 0 || y == V_RES - 1) return COL_WHITE;
        return COL_BLACK;
      end
      default: return ((x ^ y) & 1) ? COL_WHITE : COL_BLACK;
    endcase
  endfunction

  // Pick a coordinate, biased toward edges and crosshair features
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned res);
    int unsigned v;
    case ($urandom_range(0, 10))
      0, 1:    v = $urandom_range(0, 2047);
      2, 3, 4: v = $urandom_range(0, res - 1);
      5:       v = $urandom_range(0, 3) + ($urandom_range(0, 1) ? 0 : res - 2);
      6:       v = res / 2 - 1 + $urandom_range(0, 2);
      7:       v = TICK_STEP * $urandom_range(0, res / TICK_STEP) + $urandom_range(0, 1);
      8:       v = TICK_LO - 1 + $urandom_range(0, TICK_HI - TICK_LO + 1);
      9:       v = ($urandom_range(0, 1) ? PATCH_NEAR : res - PATCH_FAR) - 1
                   + $urandom_range(0, PATCH_SIZE + 1);
      default: v = res - RAMP_ROWS - 1 + $urandom_range(0, 2);
    endcase
    return v[COORD_W-1:0];
  endfunction

  // Send one coordinate; enter and leave at a falling edge
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_pixel_x = x;
    in_pixel_y = y;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    color_q.push_back('{x: x, y: y, color: pattern_color(mode_shadow, x, y)});
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted color has come back
  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (color_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    wait_results_drained();
    cfg_pattern_mode = m;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_shadow = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: stall on one of four patterns, picked again at random after each run
  initial begin
    int style;
    int left;
    int cyc;
    style = 0;
    left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      cyc++;
      case (style)
        0:       out_ready = 1'b1;
        1:       out_ready = ($urandom_range(0, 9) >= 3);
        2:       out_ready = ($urandom_range(0, 9) >= 8);
        default: out_ready = (cyc % 5 >= 2);
      endcase
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    pixel_expect_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (color_q.size() == 0) begin
        $error("unexpected result transfer: pixel_color %02h", out_pixel_color);
        fail_count++;
      end else begin
        exp_px = color_q.pop_front();
        if (out_pixel_color !== exp_px.color) begin
          $error("pixel_color at (%0d,%0d): expected %02h, actual %02h",
                 exp_px.x, exp_px.y, exp_px.color, out_pixel_color);
          fail_count++;
        end
      end
    end
  end

  // Coordinates at and beyond the edges of the active area
  task automatic test_active_area_edges();
    write_mode(PAT_CHECKER);
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd1919, 11'd1079);
    send_pixel(11'd1920, 11'd0);
    send_pixel(11'd0, 11'd1080);
    send_pixel(11'd2047, 11'd2047);
  endtask

  task automatic test_stripes_and_ramp();
    write_mode(PAT_VSTRIPE);
    send_pixel(11'd1, 11'd0);
    send_pixel(11'd0, 11'd0);
    write_mode(PAT_HSTRIPE);
    send_pixel(11'd0, 11'd1);
    write_mode(PAT_RAMP);
    send_pixel(11'd1919, 11'd1079);
    send_pixel(11'd1919, 11'd0);
    send_pixel(11'd255, 11'd1015);
  endtask

  // Center lines, border, ticks and checker patches of the crosshair
  task automatic test_crosshair_features();
    write_mode(PAT_CROSS);
    send_pixel(11'd960, 11'd540);
    send_pixel(11'd500, 11'd540);
    send_pixel(11'd0, 11'd500);
    send_pixel(11'd1919, 11'd1079);
    send_pixel(11'd8, 11'd32);
    send_pixel(11'd16, 11'd11);
    send_pixel(11'd32, 11'd32);
    send_pixel(11'd1825, 11'd984);
  endtask

  task automatic test_undefined_modes();
    write_mode(MODE_SPARE_5);
    send_pixel(11'd1, 11'd0);
    write_mode(MODE_SPARE_6);
    send_pixel(11'd2, 11'd1);
    write_mode(MODE_SPARE_7);
    send_pixel(11'd1, 11'd2);
  endtask

  // Random coordinates under one mode, with one full drain midway
  task automatic test_random_mode(input logic [MODE_W-1:0] m);
    write_mode(m);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (i == RANDOM_PER_PHASE / 2) wait_results_drained();
      send_pixel(pick_coord(H_RES), pick_coord(V_RES));
    end
  endtask

  initial begin
    // Hold reset, then release it at a falling edge
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_active_area_edges();
    test_stripes_and_ramp();
    test_crosshair_features();
    test_undefined_modes();
    test_random_mode(PAT_CROSS);
    test_random_mode(PAT_CHECKER);
    test_random_mode(PAT_RAMP);
    test_random_mode(PAT_VSTRIPE);
    test_random_mode(MODE_SPARE_7);
    test_random_mode(PAT_HSTRIPE);
    test_random_mode(MODE_SPARE_5);
    test_random_mode(PAT_CROSS);
    test_random_mode(MODE_SPARE_6);
    test_random_mode(PAT_RAMP);

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
